@@ design/ute_pkg.sv @@
// Shared types and constants for the UTF-16 to TSCII encoder.
// Holds the sorted encode table used by the back-end lookup sequencer.
// No dependencies.
package ute_pkg;

    localparam logic [15:0] ASCII_LIMIT = 16'h0080;
    localparam logic [7:0]  QMARK       = 8'h3F;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;
    localparam int          ROM_DEPTH   = 128;
    localparam int          IDX_BITS    = 7;
    localparam int          KEY_BITS    = 48;

    typedef struct packed {
        logic [15:0] unit;
        logic        eot;
        logic        ascii;
    } unit_t;

    typedef struct packed {
        logic [7:0]  tscii_byte;
        logic        was_invalid;
        logic [15:0] invalid_total;
        logic        last_of_text;
    } result_t;

    typedef struct packed {
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] k2;
        logic [7:0]  code;
    } rom_row_t;

    // Sorted by (k0, k1, k2); the tail is padded with max keys and code 0 (no match).
    localparam rom_row_t ENC_ROM [ROM_DEPTH] = '{
        '{16'h00A0,16'h0,16'h0,8'hA0}, '{16'h00A9,16'h0,16'h0,8'hA9},
        '{16'h0B83,16'h0,16'h0,8'hB7}, '{16'h0B85,16'h0,16'h0,8'hAB},
        '{16'h0B86,16'h0,16'h0,8'hAC}, '{16'h0B87,16'h0,16'h0,8'hAD},
        '{16'h0B88,16'h0,16'h0,8'hAE}, '{16'h0B89,16'h0,16'h0,8'hAF},
        '{16'h0B8A,16'h0,16'h0,8'hB0}, '{16'h0B8E,16'h0,16'h0,8'hB1},
        '{16'h0B8F,16'h0,16'h0,8'hB2}, '{16'h0B90,16'h0,16'h0,8'hB3},
        '{16'h0B92,16'h0,16'h0,8'hB4}, '{16'h0B93,16'h0,16'h0,8'hB5},
        '{16'h0B94,16'h0,16'h0,8'hB6}, '{16'h0B95,16'h0,16'h0,8'hB8},
        '{16'h0B95,16'h0B82,16'h0,8'hEC}, '{16'h0B95,16'h0BC1,16'h0,8'hCC},
        '{16'h0B95,16'h0BC2,16'h0,8'hDC},
        '{16'h0B99,16'h0,16'h0,8'hB9}, '{16'h0B99,16'h0B82,16'h0,8'hED},
        '{16'h0B99,16'h0BC1,16'h0,8'h99},
        '{16'h0B99,16'h0BC2,16'h0,8'h9B}, '{16'h0B9A,16'h0,16'h0,8'hBA},
        '{16'h0B9A,16'h0B82,16'h0,8'hEE},
        '{16'h0B9A,16'h0BC1,16'h0,8'hCD}, '{16'h0B9A,16'h0BC2,16'h0,8'hDD},
        '{16'h0B9C,16'h0,16'h0,8'h83},
        '{16'h0B9C,16'h0B82,16'h0,8'h88}, '{16'h0B9E,16'h0,16'h0,8'hBB},
        '{16'h0B9E,16'h0B82,16'h0,8'hEF},
        '{16'h0B9E,16'h0BC1,16'h0,8'h9A}, '{16'h0B9E,16'h0BC2,16'h0,8'h9C},
        '{16'h0B9F,16'h0,16'h0,8'hBC},
        '{16'h0B9F,16'h0B82,16'h0,8'hF0}, '{16'h0B9F,16'h0BBF,16'h0,8'hCA},
        '{16'h0B9F,16'h0BC0,16'h0,8'hCB},
        '{16'h0B9F,16'h0BC1,16'h0,8'hCE}, '{16'h0B9F,16'h0BC2,16'h0,8'hDE},
        '{16'h0BA1,16'h0B82,16'h0,8'hF2},
        '{16'h0BA3,16'h0,16'h0,8'hBD}, '{16'h0BA3,16'h0B82,16'h0,8'hF1},
        '{16'h0BA3,16'h0BC1,16'h0,8'hCF},
        '{16'h0BA3,16'h0BC2,16'h0,8'hDF}, '{16'h0BA4,16'h0,16'h0,8'hBE},
        '{16'h0BA4,16'h0BC1,16'h0,8'hD0},
        '{16'h0BA4,16'h0BC2,16'h0,8'hE0}, '{16'h0BA8,16'h0,16'h0,8'hBF},
        '{16'h0BA8,16'h0B82,16'h0,8'hF3},
        '{16'h0BA8,16'h0BC1,16'h0,8'hD1}, '{16'h0BA8,16'h0BC2,16'h0,8'hE1},
        '{16'h0BA9,16'h0,16'h0,8'hC9},
        '{16'h0BA9,16'h0B82,16'h0,8'hFD}, '{16'h0BA9,16'h0BC1,16'h0,8'hDB},
        '{16'h0BA9,16'h0BC2,16'h0,8'hEB},
        '{16'h0BAA,16'h0,16'h0,8'hC0}, '{16'h0BAA,16'h0B82,16'h0,8'hF4},
        '{16'h0BAA,16'h0BC1,16'h0,8'hD2},
        '{16'h0BAA,16'h0BC2,16'h0,8'hE2}, '{16'h0BAE,16'h0,16'h0,8'hC1},
        '{16'h0BAE,16'h0B82,16'h0,8'hF5},
        '{16'h0BAE,16'h0BC1,16'h0,8'hD3}, '{16'h0BAE,16'h0BC2,16'h0,8'hE3},
        '{16'h0BAF,16'h0,16'h0,8'hC2},
        '{16'h0BAF,16'h0B82,16'h0,8'hF6}, '{16'h0BAF,16'h0BC1,16'h0,8'hD4},
        '{16'h0BAF,16'h0BC2,16'h0,8'hE4},
        '{16'h0BB0,16'h0,16'h0,8'hC3}, '{16'h0BB0,16'h0B82,16'h0,8'hF7},
        '{16'h0BB0,16'h0BC1,16'h0,8'hD5},
        '{16'h0BB0,16'h0BC2,16'h0,8'hE5}, '{16'h0BB1,16'h0,16'h0,8'hC8},
        '{16'h0BB1,16'h0B82,16'h0,8'hFC},
        '{16'h0BB1,16'h0BC1,16'h0,8'hDA}, '{16'h0BB1,16'h0BC2,16'h0,8'hEA},
        '{16'h0BB2,16'h0,16'h0,8'hC4},
        '{16'h0BB2,16'h0B82,16'h0,8'hF8}, '{16'h0BB2,16'h0BC1,16'h0,8'hD6},
        '{16'h0BB2,16'h0BC2,16'h0,8'hE6},
        '{16'h0BB3,16'h0,16'h0,8'hC7}, '{16'h0BB3,16'h0B82,16'h0,8'hFB},
        '{16'h0BB3,16'h0BC1,16'h0,8'hD9},
        '{16'h0BB3,16'h0BC2,16'h0,8'hE9}, '{16'h0BB4,16'h0,16'h0,8'hC6},
        '{16'h0BB4,16'h0B82,16'h0,8'hFA},
        '{16'h0BB4,16'h0BC1,16'h0,8'hD8}, '{16'h0BB4,16'h0BC2,16'h0,8'hE8},
        '{16'h0BB5,16'h0,16'h0,8'hC5},
        '{16'h0BB5,16'h0B82,16'h0,8'hF9}, '{16'h0BB5,16'h0BC1,16'h0,8'hD7},
        '{16'h0BB5,16'h0BC2,16'h0,8'hE7},
        '{16'h0BB7,16'h0,16'h0,8'h84}, '{16'h0BB7,16'h0B82,16'h0,8'h89},
        '{16'h0BB8,16'h0,16'h0,8'h85},
        '{16'h0BB8,16'h0B82,16'h0,8'h8A}, '{16'h0BB9,16'h0,16'h0,8'h86},
        '{16'h0BB9,16'h0B82,16'h0,8'h8B},
        '{16'h0BBE,16'h0,16'h0,8'hA1}, '{16'h0BBF,16'h0,16'h0,8'hA2},
        '{16'h0BC0,16'h0,16'h0,8'hA3}, '{16'h0BC1,16'h0,16'h0,8'hA4},
        '{16'h0BC2,16'h0,16'h0,8'hA5}, '{16'h0BC6,16'h0,16'h0,8'hA6},
        '{16'h0BC7,16'h0,16'h0,8'hA7}, '{16'h0BC8,16'h0,16'h0,8'hA8},
        '{16'h0BCC,16'h0,16'h0,8'hAA}, '{16'h0BE6,16'h0,16'h0,8'h80},
        '{16'h0BE7,16'h0,16'h0,8'h81},
        '{16'h0BE7,16'h0BB7,16'h0,8'h87}, '{16'h0BE7,16'h0BB7,16'h0B82,8'h8C},
        '{16'h0BE8,16'h0,16'h0,8'h8D},
        '{16'h0BE9,16'h0,16'h0,8'h8E}, '{16'h0BEA,16'h0,16'h0,8'h8F},
        '{16'h0BEB,16'h0,16'h0,8'h90}, '{16'h0BEC,16'h0,16'h0,8'h95},
        '{16'h0BED,16'h0,16'h0,8'h96}, '{16'h0BEE,16'h0,16'h0,8'h97},
        '{16'h0BEF,16'h0,16'h0,8'h98}, '{16'h0BF0,16'h0,16'h0,8'h9D},
        '{16'h0BF1,16'h0,16'h0,8'h9E}, '{16'h0BF2,16'h0,16'h0,8'h9F},
        '{16'h2018,16'h0,16'h0,8'h91}, '{16'h2019,16'h0,16'h0,8'h92},
        '{16'h201C,16'h0,16'h0,8'h93}, '{16'h201C,16'h0,16'h0,8'h94},
        '{16'hFFFF,16'hFFFF,16'hFFFF,8'h00}, '{16'hFFFF,16'hFFFF,16'hFFFF,8'h00},
        '{16'hFFFF,16'hFFFF,16'hFFFF,8'h00}
    };

endpackage

@@ design/ute_front.sv @@
// Front end of the encoder: input handshake, ASCII classification and a
// two-beat queue toward the back end. Depends on ute_pkg.
module ute_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [15:0]    code_unit,
    input  logic           end_of_text,
    output logic           q_valid,
    output ute_pkg::unit_t q_entry,
    input  logic           q_pop
);

    ute_pkg::unit_t mem_reg [2];
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic           push;
    logic           pop;
    ute_pkg::unit_t in_entry;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_entry.unit  = code_unit;
        in_entry.eot   = end_of_text;
        in_entry.ascii = (code_unit < ute_pkg::ASCII_LIMIT);
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

@@ design/ute_back.sv @@
// Back end of the encoder: three-unit window, greedy longest-match sequencer
// with a binary search over the encode table, invalid counter and result
// register. Depends on ute_pkg.
module ute_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ute_pkg::unit_t   q_entry,
    output logic             q_pop,
    input  logic             invalid_to_null,
    output logic             res_valid,
    output ute_pkg::result_t res,
    input  logic             out_stall
);

    typedef enum logic [4:0] {
        ST_FILL   = 5'b00001,
        ST_SETTLE = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    localparam int IB = ute_pkg::IDX_BITS;
    localparam int KB = ute_pkg::KEY_BITS;

    state_t                state_reg, state_next;
    logic [15:0]           w_reg [3];
    logic [15:0]           w_next [3];
    logic                  a_reg [3];
    logic                  a_next [3];
    logic [1:0]            n_reg, n_next;
    logic                  flush_reg, flush_next;
    logic [1:0]            len_reg, len_next;
    logic [1:0]            used_reg, used_next;
    logic [KB-1:0]         tgt_reg, tgt_next;
    logic [IB-1:0]         pos_reg, pos_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  bad_reg, bad_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  res_valid_reg, res_valid_next;
    ute_pkg::result_t      res_reg, res_next;

    logic [IB-1:0]         mask;
    logic [IB-1:0]         probe_idx;
    ute_pkg::rom_row_t     probe_row;
    ute_pkg::rom_row_t     check_row;
    logic                  check_hit;
    logic                  can_emit;
    logic [1:0]            n_left;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [COUNT_BITS+15:0] cnt_wide;

    assign mask      = IB'(1) << bit_reg;
    assign probe_idx = pos_reg | (mask - IB'(1));
    assign probe_row = ute_pkg::ENC_ROM[probe_idx];
    assign check_row = ute_pkg::ENC_ROM[pos_reg];
    assign check_hit = ({check_row.k0, check_row.k1, check_row.k2} == tgt_reg)
                       && (check_row.code != 8'h00);
    assign can_emit  = !res_valid_reg || !out_stall;
    assign n_left    = n_reg - used_reg;
    assign cnt_new   = (bad_reg && !(&cnt_reg)) ? cnt_reg + COUNT_BITS'(1) : cnt_reg;
    assign cnt_wide  = {16'h0000, cnt_new};

    assign q_pop     = (state_reg == ST_FILL) && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        flush_next     = flush_reg;
        len_next       = len_reg;
        used_next      = used_reg;
        tgt_next       = tgt_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        bad_next       = bad_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && out_stall;

        unique case (state_reg)
            ST_FILL:
            begin
                if (q_valid)
                begin
                    w_next[n_reg] = q_entry.unit;
                    a_next[n_reg] = q_entry.ascii;
                    n_next        = n_reg + 2'd1;
                    flush_next    = q_entry.eot;
                    if (q_entry.eot || n_reg == 2'd2)
                    begin
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                bad_next = 1'b0;
                if (a_reg[0])
                begin
                    byte_next  = w_reg[0][7:0];
                    used_next  = 2'd1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    len_next   = n_reg;
                    tgt_next   = {w_reg[0],
                                  (n_reg >= 2'd2) ? w_reg[1] : 16'h0000,
                                  (n_reg == 2'd3) ? w_reg[2] : 16'h0000};
                    pos_next   = '0;
                    bit_next   = 3'(IB - 1);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if ({probe_row.k0, probe_row.k1, probe_row.k2} < tgt_reg)
                begin
                    pos_next = pos_reg | mask;
                end
                if (bit_reg == 3'd0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            ST_CHECK:
            begin
                if (check_hit)
                begin
                    byte_next  = check_row.code;
                    used_next  = len_reg;
                    state_next = ST_EMIT;
                end
                else if (len_reg > 2'd1)
                begin
                    len_next   = len_reg - 2'd1;
                    tgt_next   = {tgt_reg[47:32],
                                  (len_reg == 2'd3) ? tgt_reg[31:16] : 16'h0000,
                                  16'h0000};
                    pos_next   = '0;
                    bit_next   = 3'(IB - 1);
                    state_next = ST_SEARCH;
                end
                else
                begin
                    byte_next  = invalid_to_null ? ute_pkg::NUL_BYTE : ute_pkg::QMARK;
                    bad_next   = 1'b1;
                    used_next  = 2'd1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    res_valid_next         = 1'b1;
                    res_next.tscii_byte    = byte_reg;
                    res_next.was_invalid   = bad_reg;
                    res_next.invalid_total = cnt_wide[15:0];
                    res_next.last_of_text  = flush_reg && (n_left == 2'd0);
                    cnt_next               = cnt_new;
                    n_next                 = n_left;
                    if (used_reg == 2'd1)
                    begin
                        w_next[0] = w_reg[1];
                        w_next[1] = w_reg[2];
                        a_next[0] = a_reg[1];
                        a_next[1] = a_reg[2];
                    end
                    else if (used_reg == 2'd2)
                    begin
                        w_next[0] = w_reg[2];
                        a_next[0] = a_reg[2];
                    end
                    if (flush_reg && n_left != 2'd0)
                    begin
                        state_next = ST_SETTLE;
                    end
                    else
                    begin
                        flush_next = 1'b0;
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            n_reg         <= 2'd0;
            flush_reg     <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            flush_reg     <= flush_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        a_reg    <= a_next;
        len_reg  <= len_next;
        used_reg <= used_next;
        tgt_reg  <= tgt_next;
        pos_reg  <= pos_next;
        bit_reg  <= bit_next;
        byte_reg <= byte_next;
        bad_reg  <= bad_next;
        res_reg  <= res_next;
    end

endmodule

@@ design/unicode_to_tscii_encoder.sv @@
// Top level of the UTF-16 to TSCII encoder: APB register, front end and back end.
// Depends on ute_pkg, ute_front and ute_back.
//
// Input channel: one UTF-16 code unit per beat (code_unit, end_of_text) on
// in_valid/in_stall. Output channel: one TSCII byte per beat (tscii_byte,
// was_invalid, invalid_total, last_of_text) on out_valid/out_stall.
// Units are held until three are present or end_of_text arrives; an
// end_of_text beat flushes the window and gives up to three bytes, the last
// one flagged last_of_text.
// Flow: the front queue takes two beats while the back end is busy. In the
// back end each unit is loaded in the fill step. An ASCII group then passes
// through settle and emit. A non-ASCII group passes a setup step, then per table
// lookup 7 binary-search probes of the 128-row table and a compare, up to
// three lookups (three-, two-, then one-unit key), and an emit step.
// Reset: window empty, invalid counter zero, invalid_to_null cleared.
// A stalled output holds its beat; the back end waits in its emit step and
// the front queue fills, then raises in_stall.
// Register 0 (byte address 0): bit 0 invalid_to_null.
module unicode_to_tscii_encoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tscii_byte,
    output logic        was_invalid,
    output logic [15:0] invalid_total,
    output logic        last_of_text
);

    localparam logic REG_INVALID_TO_NULL = 1'b0;

    logic             inv_null_reg;
    logic             inv_null_next;
    logic             reg_write;
    logic             q_valid;
    logic             q_pop;
    ute_pkg::unit_t   q_entry;
    ute_pkg::result_t res;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready && (paddr[2] == REG_INVALID_TO_NULL);
    assign inv_null_next = reg_write ? pwdata[0] : inv_null_reg;
    assign prdata    = (paddr[2] == REG_INVALID_TO_NULL) ? {31'h0, inv_null_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_null_reg <= 1'b0;
        end
        else
        begin
            inv_null_reg <= inv_null_next;
        end
    end

    ute_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    ute_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .invalid_to_null (inv_null_reg),
        .res_valid       (out_valid),
        .res             (res),
        .out_stall       (out_stall)
    );

    assign tscii_byte    = res.tscii_byte;
    assign was_invalid   = res.was_invalid;
    assign invalid_total = res.invalid_total;
    assign last_of_text  = res.last_of_text;

    // replacement byte follows the configured mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_invalid) |->
            ((inv_null_reg && tscii_byte == ute_pkg::NUL_BYTE) ||
             (!inv_null_reg && tscii_byte == ute_pkg::QMARK)))
        else $error("replacement byte does not match invalid_to_null");

    // after a replacement the visible count cannot be zero (no wrap)
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_invalid && COUNT_BITS <= 16) |-> (invalid_total != 16'h0000))
        else $error("invalid counter zero on a replacement byte");

    // the front end only hands a unit over when it has one
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

endmodule
